[src/spt_pkg.sv]
// Package for the sorted position table: status and op codes, widths, result word.
// No dependencies.
package spt_pkg;
  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_ERASE   = 2'd1,
    OP_NEAREST = 2'd2,
    OP_PROBE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_DUP      = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4,
    ST_RANGE    = 3'd5
  } status_t;

  localparam int POS_W  = 64;
  localparam int MASS_W = 32;
  localparam int CNT_W  = 11;

  typedef struct packed {
    logic [2:0]        status;
    logic [POS_W-1:0]  center_pos;
    logic [MASS_W-1:0] center_mass;
    logic              has_left;
    logic [POS_W-1:0]  left_pos;
    logic [MASS_W-1:0] left_mass;
    logic              has_right;
    logic [POS_W-1:0]  right_pos;
    logic [MASS_W-1:0] right_mass;
    logic              occupied;
    logic [CNT_W-1:0]  entry_count;
  } result_t;
endpackage

[src/spt_if.sv]
// Valid/ready channel interfaces for the sorted position table.
// Depends on spt_pkg.
interface spt_req_if import spt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [POS_W-1:0]  position;
  logic [MASS_W-1:0] mass;
  modport source (output valid, output op, output position, output mass, input ready);
  modport sink (input valid, input op, input position, input mass, output ready);
endinterface

interface spt_rsp_if import spt_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface spt_cfg_if import spt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/spt_mem.sv]
// Entry memory: position and mass, one write and one registered read port.
// Depends on spt_pkg.
module spt_mem import spt_pkg::*; #(
  parameter int CAPACITY = 1024,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [POS_W-1:0]  wpos,
  input  logic [MASS_W-1:0] wmass,
  input  logic [AW-1:0]     raddr,
  output logic [POS_W-1:0]  rpos,
  output logic [MASS_W-1:0] rmass
);
  logic [POS_W-1:0]  pos_mem  [CAPACITY];
  logic [MASS_W-1:0] mass_mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      pos_mem[waddr]  <= wpos;
      mass_mem[waddr] <= wmass;
    end
    rpos  <= pos_mem[raddr];
    rmass <= mass_mem[raddr];
  end
endmodule

[src/sorted_position_table.sv]
// Sorted position table top level: sequencer around one entry memory.
// Depends on spt_pkg, spt_if, spt_mem.
//
// Use: one request word (op, position, mass) enters on req; one result word
// leaves on rsp for each request. cfg writes domain_length; write it only
// while idle, the block itself does not enforce this. The block takes a
// request only when idle; it holds the result until rsp is taken, then
// returns to idle. The memory has one read port, each read being an address
// step and then a registered data step, and the sequencer works as follows:
//   binary search: one read per probe, up to log2(fill+1) probes, then a decode step,
//   insert shift: a read and a write per entry above the insert point,
//   erase shift: a read and a write per entry above the erased one,
//   nearest: reads of the neighbour entries, one at a time.
// Reset (synchronous) empties the table and sets domain_length to all ones;
// the memory itself is not cleared, entries at or above the fill count are
// never used. A stalled receiver just holds the block in its result state.
module sorted_position_table import spt_pkg::*; #(
  parameter int CAPACITY = 1024,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int IW = $clog2(CAPACITY + 1)
) (
  input logic         clk,
  input logic         rst,
  spt_req_if.sink     req,
  spt_rsp_if.source   rsp,
  spt_cfg_if.sink     cfg
);
  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_SRCH  = 11'b00000000010,
    S_SWAIT = 11'b00000000100,
    S_DEC   = 11'b00000001000,
    S_SHRD  = 11'b00000010000,
    S_SHWR  = 11'b00000100000,
    S_NRD   = 11'b00001000000,
    S_NWAIT = 11'b00010000000,
    S_PICK  = 11'b00100000000,
    S_FIN   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state;
  logic [POS_W-1:0]  domain_length;
  logic [IW-1:0]     fill;
  logic [1:0]        op;
  logic [POS_W-1:0]  key;
  logic [MASS_W-1:0] kmass;
  logic [IW-1:0]     lo, hi, idx, sh;
  logic [2:0]        nstep;
  logic [POS_W-1:0]  lpos, cpos;
  logic [MASS_W-1:0] lmass, cmass;
  logic [IW-1:0]     cidx;
  result_t           res;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [POS_W-1:0]  wpos, rpos;
  logic [MASS_W-1:0] wmass, rmass;
  logic [IW-1:0]     mid, ridx;

  spt_mem #(.CAPACITY(CAPACITY)) u_mem (
    .clk, .we, .waddr, .wpos, .wmass, .raddr, .rpos, .rmass
  );

  assign mid = lo + ((hi - lo) >> 1);
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);
  assign rsp.data  = res;
  assign cfg.ready = 1'b1;

  logic found;
  assign found = (idx < fill) && (cpos == key);

  // read address per state
  always_comb begin
    ridx = mid;
    unique case (state)
      S_SRCH, S_SWAIT: ridx = mid;
      S_SHRD:          ridx = (op == OP_INSERT) ? sh - 1'b1 : sh;
      S_SHWR:          ridx = sh;
      S_NRD, S_NWAIT:  ridx = cidx;
      default:         ridx = idx;
    endcase
    raddr = ridx[AW-1:0];
  end

  always_ff @(posedge clk) begin
    we <= 1'b0;
    if (rst) begin
      state         <= S_IDLE;
      fill          <= '0;
      domain_length <= '1;
    end else begin
      if (cfg.valid) domain_length <= cfg.data;
      unique case (state)
        S_IDLE: if (req.valid) begin
          op    <= req.op;
          key   <= req.position;
          kmass <= req.mass;
          lo    <= '0;
          hi    <= fill;
          res   <= '0;
          state <= S_SRCH;
        end
        S_SRCH: begin
          if (lo < hi) state <= S_SWAIT;
          else begin
            idx   <= lo;
            state <= S_DEC;
          end
        end
        S_SWAIT: begin
          if (rpos < key) lo <= mid + 1'b1;
          else hi <= mid;
          state <= S_SRCH;
        end
        S_DEC: begin
          // rpos/rmass now hold entry idx
          cpos  <= rpos;
          cmass <= rmass;
          state <= S_FIN;
        end
        S_FIN: begin
          res.entry_count <= CNT_W'(fill);
          state <= S_OUT;
          priority if (op == OP_INSERT) begin
            if (found) res.status <= ST_DUP;
            else if (fill >= IW'(CAPACITY)) res.status <= ST_FULL;
            else begin
              res.status <= ST_OK;
              sh    <= fill;
              state <= S_SHRD;
            end
          end else if (op == OP_ERASE) begin
            if (!found) res.status <= ST_NOTFOUND;
            else begin
              res.status <= ST_OK;
              sh    <= idx + 1'b1;
              state <= S_SHRD;
            end
          end else if (key == '0 || key > domain_length) begin
            res.status <= ST_RANGE;
          end else if (op == OP_PROBE) begin
            res.status   <= ST_OK;
            res.occupied <= found;
          end else if (fill == '0) begin
            res.status <= ST_EMPTY;
          end else begin
            res.status <= ST_OK;
            cidx  <= (idx == '0) ? '0 : idx - 1'b1;
            nstep <= 3'd0;
            state <= S_NRD;
          end
        end
        S_SHRD: begin
          // insert moves sh-1 -> sh going down; erase moves sh -> sh-1 going up
          if (op == OP_INSERT) begin
            if (sh == idx) begin
              we    <= 1'b1;
              waddr <= idx[AW-1:0];
              wpos  <= key;
              wmass <= kmass;
              fill  <= fill + 1'b1;
              res.entry_count <= CNT_W'(fill + 1'b1);
              state <= S_OUT;
            end else begin
              sh    <= sh - 1'b1;
              state <= S_SHWR;
            end
          end else begin
            if (sh == fill) begin
              fill  <= fill - 1'b1;
              res.entry_count <= CNT_W'(fill - 1'b1);
              state <= S_OUT;
            end else state <= S_SHWR;
          end
        end
        S_SHWR: begin
          we    <= 1'b1;
          wpos  <= rpos;
          wmass <= rmass;
          if (op == OP_INSERT) waddr <= AW'(sh + 1'b1);
          else begin
            waddr <= AW'(sh - 1'b1);
            sh    <= sh + 1'b1;
          end
          state <= S_SHRD;
        end
        S_NRD: state <= S_NWAIT;
        S_NWAIT: begin
          state <= S_NRD;
          unique case (nstep)
            3'd0: begin
              lpos  <= rpos;
              lmass <= rmass;
              cidx  <= (idx == fill) ? fill - 1'b1 : idx;
              nstep <= 3'd1;
            end
            3'd1: begin
              // rpos = lower-bound entry; pick center
              if (((lpos > key) ? lpos - key : key - lpos) <
                  ((rpos > key) ? rpos - key : key - rpos)) begin
                res.center_pos  <= lpos;
                res.center_mass <= lmass;
                cidx <= (idx > IW'(1)) ? idx - 2'd2 : '0;
                res.has_left  <= (idx > IW'(1));
                res.has_right <= 1'b1;
                res.right_pos <= rpos;
                res.right_mass <= rmass;
                nstep <= (idx > IW'(1)) ? 3'd2 : 3'd4;
                if (idx <= IW'(1)) state <= S_OUT;
              end else begin
                res.center_pos  <= rpos;
                res.center_mass <= rmass;
                res.has_left    <= (cidx != '0);
                res.has_right   <= (cidx + 1'b1 < fill);
                if (cidx != '0) begin
                  cidx  <= cidx - 1'b1;
                  nstep <= 3'd2;
                end else if (cidx + 1'b1 < fill) begin
                  cidx  <= cidx + 1'b1;
                  nstep <= 3'd3;
                end else state <= S_OUT;
              end
            end
            3'd2: begin
              res.left_pos  <= rpos;
              res.left_mass <= rmass;
              if (res.has_right && res.right_pos == '0 && res.right_mass == '0
                  && (cidx + 2'd2 < fill) && (res.center_pos != lpos)) begin
                cidx  <= cidx + 2'd2;
                nstep <= 3'd3;
              end else state <= S_OUT;
            end
            default: begin
              res.right_pos  <= rpos;
              res.right_mass <= rmass;
              state <= S_OUT;
            end
          endcase
        end
        S_OUT: if (rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[src/spt_checker.sv]
// Port-level checker for the sorted position table, bound to the top level.
// Depends on spt_pkg and the top level's ports.
module spt_checker import spt_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    req_valid,
  input logic    req_ready,
  input logic    rsp_valid,
  input logic    rsp_ready,
  input result_t rsp_data
);
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && rsp_valid)) else $error("request taken with result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_data)) else $error("result changed");
  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_data.status <= ST_RANGE) else $error("bad status");
  a_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_data.entry_count <= 11'd1024) else $error("count overflow");
endmodule

bind sorted_position_table spt_checker u_chk (
  .clk, .rst,
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
